FILE: rtl/scm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sorted counted ID multiset.
// No dependencies; every other file imports this package.
package scm_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int ID_W          = 16;
  localparam int CNT_W         = 16;
  localparam int OP_W          = 2;
  localparam int ST_W          = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_SATURATED = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

endpackage

FILE: rtl/scm_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for requests and responses of the multiset.
// Depends on scm_pkg for the payload widths.
interface scm_req_if
  import scm_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [ID_W-1:0] id;

  modport source (output valid, op, id, input ready);
  modport sink   (input valid, op, id, output ready);
endinterface

interface scm_rsp_if
  import scm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  entry_id;
  logic [CNT_W-1:0] entry_count;
  logic [ST_W-1:0]  status;
  logic             last;

  modport source (output valid, entry_id, entry_count, status, last, input ready);
  modport sink   (input valid, entry_id, entry_count, status, last, output ready);
endinterface

FILE: rtl/sorted_counted_id_multiset.sv
`timescale 1ns / 1ps
// Top level of the sorted counted ID multiset: sequencer and entry memory.
// Depends on scm_pkg and the channel interfaces in scm_if.sv.

// A table of up to DEPTH IDs kept in ascending order in a single-port-write,
// single-port-read memory with a registered read, each ID with a 16-bit count.
// One item is handled at a time; the request channel is ready only while the
// sequencer is idle. The steps are set by the memory's one read and one write
// port. Insert and remove run a binary search over the n entries, each step a
// read at the midpoint and a compare, then read the entry found and check it.
// Moving entries costs a read and a write per entry that has to move (entries
// above the insert point, or above a removed entry), then a new entry is
// written or a removed one retired. A count update is written in the check
// step. The result is then handed to the output register once that is free.
// List reads each entry, takes the registered read data and emits it, in turn,
// waiting the same way, and gives one EMPTY response for an empty table. An
// unused op code is absorbed with no response. The memory needs no clearing
// pass: only entries below the occupancy count are ever used.
module sorted_counted_id_multiset
  import scm_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  scm_req_if.sink    req,
  scm_rsp_if.source  rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int EW = ID_W + CNT_W;
  localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SRCH      = 4'd1;
  localparam logic [3:0] S_SWAIT     = 4'd2;
  localparam logic [3:0] S_CHECK     = 4'd3;
  localparam logic [3:0] S_UP_RD     = 4'd4;
  localparam logic [3:0] S_UP_WR     = 4'd5;
  localparam logic [3:0] S_INS_WR    = 4'd6;
  localparam logic [3:0] S_DN_RD     = 4'd7;
  localparam logic [3:0] S_DN_WR     = 4'd8;
  localparam logic [3:0] S_LIST_RD   = 4'd9;
  localparam logic [3:0] S_LIST_WAIT = 4'd10;
  localparam logic [3:0] S_EMIT      = 4'd11;

  logic [3:0]       state;
  logic [OP_W-1:0]  op_r;
  logic [ID_W-1:0]  id_r;
  logic [OW-1:0]    occ;
  logic [OW-1:0]    lo;
  logic [OW-1:0]    hi;
  logic [OW-1:0]    mid;
  logic [OW-1:0]    ptr;

  logic [ID_W-1:0]  res_id;
  logic [CNT_W-1:0] res_count;
  logic [ST_W-1:0]  res_status;
  logic             res_last;

  logic             out_valid;
  logic [ID_W-1:0]  out_id;
  logic [CNT_W-1:0] out_count;
  logic [ST_W-1:0]  out_status;
  logic             out_last;
  logic             out_free;

  logic [EW-1:0]    mem [DEPTH];
  logic [EW-1:0]    rdata;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [EW-1:0]    wdata;

  logic [ID_W-1:0]  rd_id;
  logic [CNT_W-1:0] rd_count;
  logic             found;

  assign rd_id    = rdata[EW-1:CNT_W];
  assign rd_count = rdata[CNT_W-1:0];
  assign mid      = lo + ((hi - lo) >> 1);
  assign found    = (lo < occ) && (rd_id == id_r);
  assign out_free = !out_valid || rsp.ready;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.entry_id    = out_id;
  assign rsp.entry_count = out_count;
  assign rsp.status      = out_status;
  assign rsp.last        = out_last;

  // Memory port control
  always_comb begin
    raddr = lo[AW-1:0];
    we    = 1'b0;
    waddr = lo[AW-1:0];
    wdata = {id_r, rd_count};
    case (state)
      S_SRCH: begin
        raddr = (lo < hi) ? mid[AW-1:0] : lo[AW-1:0];
      end
      S_CHECK: begin
        if (found && (op_r == OP_INSERT) && (rd_count != COUNT_MAX)) begin
          we    = 1'b1;
          wdata = {id_r, rd_count + CNT_W'(1)};
        end else if (found && (op_r == OP_REMOVE) && (rd_count > CNT_W'(1))) begin
          we    = 1'b1;
          wdata = {id_r, rd_count - CNT_W'(1)};
        end
      end
      S_UP_RD: raddr = ptr[AW-1:0];
      S_UP_WR: begin
        we    = 1'b1;
        waddr = AW'(ptr + OW'(1));
        wdata = rdata;
      end
      S_INS_WR: begin
        we    = 1'b1;
        waddr = lo[AW-1:0];
        wdata = {id_r, CNT_W'(1)};
      end
      S_DN_RD: raddr = AW'(ptr + OW'(1));
      S_DN_WR: begin
        we    = 1'b1;
        waddr = ptr[AW-1:0];
        wdata = rdata;
      end
      S_LIST_RD: raddr = ptr[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r      <= req.op;
            id_r      <= req.id;
            res_id    <= req.id;
            res_count <= '0;
            res_last  <= 1'b1;
            lo        <= '0;
            hi        <= occ;
            ptr       <= '0;
            case (req.op)
              OP_INSERT, OP_REMOVE: state <= S_SRCH;
              OP_LIST: begin
                if (occ == '0) begin
                  res_id     <= '0;
                  res_status <= ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  state <= S_LIST_RD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SRCH: begin
          state <= (lo < hi) ? S_SWAIT : S_CHECK;
        end
        S_SWAIT: begin
          if (rd_id < id_r) begin
            lo <= mid + OW'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_CHECK: begin
          state <= S_EMIT;
          if (op_r == OP_INSERT) begin
            if (found) begin
              if (rd_count == COUNT_MAX) begin
                res_count  <= COUNT_MAX;
                res_status <= ST_SATURATED;
              end else begin
                res_count  <= rd_count + CNT_W'(1);
                res_status <= ST_OK;
              end
            end else if (occ == FULL_OCC) begin
              res_status <= ST_FULL;
            end else if (lo == occ) begin
              state <= S_INS_WR;
            end else begin
              ptr   <= occ - OW'(1);
              state <= S_UP_RD;
            end
          end else begin
            if (!found) begin
              res_status <= ST_NOT_FOUND;
            end else if (rd_count > CNT_W'(1)) begin
              res_count  <= rd_count - CNT_W'(1);
              res_status <= ST_OK;
            end else begin
              ptr   <= lo;
              state <= S_DN_RD;
            end
          end
        end
        S_UP_RD: state <= S_UP_WR;
        S_UP_WR: begin
          // entries move up from the top down to the insert point
          if (ptr == lo) begin
            state <= S_INS_WR;
          end else begin
            ptr   <= ptr - OW'(1);
            state <= S_UP_RD;
          end
        end
        S_INS_WR: begin
          occ        <= occ + OW'(1);
          res_count  <= CNT_W'(1);
          res_status <= ST_OK;
          state      <= S_EMIT;
        end
        S_DN_RD: begin
          if (ptr + OW'(1) == occ) begin
            occ        <= occ - OW'(1);
            res_count  <= '0;
            res_status <= ST_OK;
            state      <= S_EMIT;
          end else begin
            state <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          ptr   <= ptr + OW'(1);
          state <= S_DN_RD;
        end
        S_LIST_RD: state <= S_LIST_WAIT;
        S_LIST_WAIT: begin
          res_id     <= rd_id;
          res_count  <= rd_count;
          res_status <= ST_OK;
          res_last   <= (ptr + OW'(1) == occ);
          state      <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid  <= 1'b1;
            out_id     <= res_id;
            out_count  <= res_count;
            out_status <= res_status;
            out_last   <= res_last;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              ptr   <= ptr + OW'(1);
              state <= S_LIST_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/scm_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the multiset's response channel, and their binding.
// Depends on scm_pkg; attaches to sorted_counted_id_multiset.
module scm_checker
  import scm_pkg::*;
  (
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [ID_W-1:0]  rsp_entry_id,
  input logic [CNT_W-1:0] rsp_entry_count,
  input logic [ST_W-1:0]  rsp_status,
  input logic             rsp_last
);

  // a stalled response transaction holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_id)
      && $stable(rsp_entry_count) && $stable(rsp_status) && $stable(rsp_last))
    else $error("response payload changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |->
      rsp_last && rsp_entry_id == '0 && rsp_entry_count == '0)
    else $error("empty-table response malformed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND) |->
      rsp_last && rsp_entry_count == '0)
    else $error("failed operation reports a count");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_SATURATED |-> rsp_last && rsp_entry_count == COUNT_MAX)
    else $error("saturated response without maximum count");

endmodule

bind sorted_counted_id_multiset scm_checker u_scm_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_entry_id    (rsp.entry_id),
  .rsp_entry_count (rsp.entry_count),
  .rsp_status      (rsp.status),
  .rsp_last        (rsp.last)
);

FILE: verif/sorted_counted_id_multiset_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the sorted counted ID multiset: directed and random
// transactions, with a shadow table that predicts every response. Depends on scm_pkg,
// the channel interfaces in scm_if.sv and the sorted_counted_id_multiset top level.
module sorted_counted_id_multiset_tb;
  import scm_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
    logic [ST_W-1:0]  status;
    logic             last;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scm_req_if req_ch ();
  scm_rsp_if rsp_ch ();

  sorted_counted_id_multiset #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table and the responses it predicts
  logic [ID_W-1:0]  shadow_id  [DEPTH];
  logic [CNT_W-1:0] shadow_cnt [DEPTH];
  int               shadow_fill = 0;
  rsp_t             awaited_rsp [$];

  int mismatches = 0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  bit calm       = 1'b0;
  int hold_left  = 0;
  int stall_left = 0;

  function automatic void await_rsp(input logic [ID_W-1:0] id, input logic [CNT_W-1:0] cnt,
                                    input logic [ST_W-1:0] status, input logic last);
    rsp_t r;
    r.id     = id;
    r.cnt    = cnt;
    r.status = status;
    r.last   = last;
    awaited_rsp.push_back(r);
  endfunction

  function automatic void shadow_apply(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    int pos;
    bit hit;
    pos = 0;
    while (pos < shadow_fill && shadow_id[pos] < id) pos++;
    hit = (pos < shadow_fill) && (shadow_id[pos] == id);
    case (op)
      OP_LIST: begin
        if (shadow_fill == 0) begin
          await_rsp('0, '0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_fill; i++)
            await_rsp(shadow_id[i], shadow_cnt[i], ST_OK, i == shadow_fill - 1);
        end
      end
      OP_INSERT: begin
        if (hit) begin
          if (shadow_cnt[pos] == COUNT_MAX) begin
            await_rsp(id, COUNT_MAX, ST_SATURATED, 1'b1);
          end else begin
            shadow_cnt[pos] = shadow_cnt[pos] + 1'b1;
            await_rsp(id, shadow_cnt[pos], ST_OK, 1'b1);
          end
        end else if (shadow_fill >= DEPTH) begin
          await_rsp(id, '0, ST_FULL, 1'b1);
        end else begin
          for (int i = shadow_fill; i > pos; i--) begin
            shadow_id[i]  = shadow_id[i-1];
            shadow_cnt[i] = shadow_cnt[i-1];
          end
          shadow_id[pos]  = id;
          shadow_cnt[pos] = CNT_W'(1);
          shadow_fill++;
          await_rsp(id, CNT_W'(1), ST_OK, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          await_rsp(id, '0, ST_NOT_FOUND, 1'b1);
        end else if (shadow_cnt[pos] > 1) begin
          shadow_cnt[pos] = shadow_cnt[pos] - 1'b1;
          await_rsp(id, shadow_cnt[pos], ST_OK, 1'b1);
        end else begin
          for (int i = pos; i < shadow_fill - 1; i++) begin
            shadow_id[i]  = shadow_id[i+1];
            shadow_cnt[i] = shadow_cnt[i+1];
          end
          shadow_fill--;
          await_rsp(id, '0, ST_OK, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] id;
    bit taken;
    do begin
      id = ID_W'($urandom_range(65535));
      taken = 1'b0;
      for (int i = 0; i < shadow_fill; i++)
        if (shadow_id[i] == id) taken = 1'b1;
    end while (taken);
    return id;
  endfunction

  // Offer one transaction; returns at the rising edge that accepts it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < gap_pct) gap = $urandom_range(9, 1);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.id    <= id;
    do @(posedge clk); while (!req_ch.ready);
    shadow_apply(op, id);
  endtask

  // Response side: long hold-off first, then random stall bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(9, 1) - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.id     = rsp_ch.entry_id;
      got.cnt    = rsp_ch.entry_count;
      got.status = rsp_ch.status;
      got.last   = rsp_ch.last;
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected response id=%h count=%0d status=%0d last=%0b",
                   $realtime, got.id, got.cnt, got.status, got.last);
      end else begin
        want = awaited_rsp.pop_front();
        if (got.id !== want.id || got.cnt !== want.cnt || got.status !== want.status ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: response mismatch: expected id=%h count=%0d status=%0d last=%0b, %s",
                     $realtime, want.id, want.cnt, want.status, want.last,
                     $sformatf("got id=%h count=%0d status=%0d last=%0b",
                               got.id, got.cnt, got.status, got.last));
        end
      end
    end
  end

  task automatic test_empty_table();
    gap_pct   = 30;
    stall_pct = 30;
    send_item(OP_LIST, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_UNUSED, 16'h1234);
    send_item(OP_LIST, 16'hFFFF);
  endtask

  task automatic test_extremes();
    send_item(OP_INSERT, 16'hFFFF);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_LIST, '0);
    send_item(OP_REMOVE, 16'h0000);
    send_item(OP_REMOVE, 16'h0000);
    send_item(OP_REMOVE, 16'h0000);
    send_item(OP_UNUSED, 16'hFFFF);
    send_item(OP_REMOVE, 16'hFFFF);
    send_item(OP_REMOVE, 16'h8000);
    send_item(OP_LIST, '0);
  endtask

  // Raise one ID's count over several transactions, the first ones with no idling
  task automatic test_count_climb();
    logic [ID_W-1:0] id;
    id        = fresh_id();
    gap_pct   = 0;
    stall_pct = 0;
    repeat (4) send_item(OP_INSERT, id);
    gap_pct   = 25;
    stall_pct = 25;
    send_item(OP_INSERT, id);
    send_item(OP_LIST, '0);
    send_item(OP_REMOVE, id);
    send_item(OP_INSERT, id);
    send_item(OP_INSERT, id);
  endtask

  task automatic test_full_table();
    logic [ID_W-1:0] added [$];
    logic [ID_W-1:0] id;
    int k;
    gap_pct   = 20;
    stall_pct = 40;
    while (shadow_fill < DEPTH) begin
      id = fresh_id();
      added.push_back(id);
      send_item(OP_INSERT, id);
    end
    send_item(OP_INSERT, fresh_id());
    send_item(OP_INSERT, added[0]);
    send_item(OP_LIST, '0);
    send_item(OP_REMOVE, added[0]);
    send_item(OP_INSERT, fresh_id());
    send_item(OP_LIST, '0);
    // drop a few of the inserted IDs in random order, last copies included
    repeat (8) begin
      k = $urandom_range(added.size() - 1);
      send_item(OP_REMOVE, added[k]);
      added.delete(k);
    end
    send_item(OP_LIST, '0);
  endtask

  // Hold the response side off while the sender keeps offering transactions
  task automatic test_output_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = 300;
    send_item(OP_LIST, '0);
    repeat (6) send_item(OP_INSERT, fresh_id());
    send_item(OP_LIST, '0);
    send_item(OP_REMOVE, shadow_id[0]);
  endtask

  task automatic random_item(input logic [ID_W-1:0] pool [$]);
    int roll;
    int pick;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    roll = $urandom_range(99);
    if (roll < 50)      op = OP_INSERT;
    else if (roll < 82) op = OP_REMOVE;
    else if (roll < 95) op = OP_LIST;
    else                op = OP_UNUSED;
    pick = $urandom_range(99);
    if (pick < 45 && shadow_fill > 0) id = shadow_id[$urandom_range(shadow_fill - 1)];
    else if (pick < 70)               id = pool[$urandom_range(pool.size() - 1)];
    else                              id = ID_W'($urandom_range(65535));
    send_item(op, id);
  endtask

  task automatic test_random_mix(input int n);
    logic [ID_W-1:0] pool [$];
    repeat (24) pool.push_back(ID_W'($urandom_range(65535)));
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        gap_pct   = $urandom_range(60);
        stall_pct = $urandom_range(60);
      end
      random_item(pool);
    end
  endtask

  task automatic test_calm_tail(input int n);
    logic [ID_W-1:0] pool [$];
    calm = 1'b1;
    repeat (8) pool.push_back(ID_W'($urandom_range(65535)));
    repeat (n) random_item(pool);
    send_item(OP_LIST, '0);
  endtask

  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op    = OP_INSERT;
    req_ch.id    = '0;
    rsp_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_extremes();
    test_count_climb();
    test_full_table();
    test_output_backpressure();
    test_random_mix(20);
    test_calm_tail(10);
    settle();
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("sorted_counted_id_multiset_tb: done, clean");
    end else begin
      $display("sorted_counted_id_multiset_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("sorted_counted_id_multiset_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/scm_pkg.sv
rtl/scm_if.sv
rtl/sorted_counted_id_multiset.sv
rtl/scm_checker.sv
verif/sorted_counted_id_multiset_tb.sv
